// ----- design/kda_pkg.sv -----
// ----------------------------------------------------------------------------
// kda_pkg: shared types and constants for the key debounce / autorepeat unit
// Register map, reset values, lane result and merge status types.
// ----------------------------------------------------------------------------
package kda_pkg;

  localparam int KEYS_DEF   = 4;
  localparam int PIN_W      = 4;
  localparam int KIDX_W     = 2;
  localparam int STEP_W     = 16;
  localparam int CNT_W      = 12;
  localparam int DBNC_W     = 8;
  localparam int MLS_W      = 8;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  localparam logic [DBNC_W-1:0] DBNC_RST  = 8'd25;
  localparam logic [CNT_W-1:0]  FIRST_RST = 12'd1000;
  localparam logic [CNT_W-1:0]  MID_RST   = 12'd500;
  localparam logic [CNT_W-1:0]  FAST_RST  = 12'd100;
  localparam logic [MLS_W-1:0]  MLS_RST   = 8'd5;
  localparam logic [STEP_W-1:0] STEP_MAX  = '1;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_FIRST    = 3'd1,
    REG_MIDDLE   = 3'd2,
    REG_FAST     = 3'd3,
    REG_MID_LAST = 3'd4
  } kda_reg_t;

  typedef struct packed {
    logic [DBNC_W-1:0] debounce;
    logic [CNT_W-1:0]  first;
    logic [CNT_W-1:0]  middle;
    logic [CNT_W-1:0]  fast;
    logic [MLS_W-1:0]  mid_last;
  } kda_cfg_t;

  typedef struct packed {
    logic              emit;
    logic              pressed;
    logic [STEP_W-1:0] step;
  } kda_evt_t;

  typedef struct packed {
    logic any;   // events still queued in the snapshot
    logic one;   // exactly one queued
    logic load;  // an event moves to the output register this cycle
  } kda_mrg_sts_t;

  // A zero delay counts as one tick.
  function automatic logic [CNT_W-1:0] fix_zero(input logic [CNT_W-1:0] v);
    fix_zero = (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

// ----- design/kda_lane.sv -----
// ----------------------------------------------------------------------------
// kda_lane: per-key debounce and typematic repeat core
// Tracks one key's raw level, debounced level, countdown and repeat step.
// ----------------------------------------------------------------------------
module kda_lane import kda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     tick,
  input  logic     raw,
  input  kda_cfg_t cfg,
  output kda_evt_t evt
);

  logic              prev_r, prev_nxt;
  logic              lvl_r, lvl_nxt;
  logic              run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [CNT_W-1:0]  dec;
  logic [STEP_W-1:0] stp_inc;
  logic [CNT_W-1:0]  rpt_dly;
  logic              pressed;

  always_comb begin
    dec     = (cnt_r != '0) ? cnt_r - CNT_W'(1) : '0;
    stp_inc = (step_r != STEP_MAX) ? step_r + STEP_W'(1) : step_r;
    // delay picked by the new step; step one is handled on the press path
    if (stp_inc >= STEP_W'(2) && stp_inc <= STEP_W'(cfg.mid_last)) begin
      rpt_dly = cfg.middle;
    end else if (stp_inc == STEP_W'(1)) begin
      rpt_dly = cfg.first;
    end else begin
      rpt_dly = cfg.fast;
    end
    pressed  = ~raw;

    prev_nxt = prev_r;
    lvl_nxt  = lvl_r;
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    evt.emit = 1'b0;

    if (tick) begin
      if (raw != prev_r) begin
        prev_nxt = raw;
        step_nxt = '0;
        cnt_nxt  = fix_zero(CNT_W'(cfg.debounce));
        run_nxt  = 1'b1;
      end else if (run_r) begin
        cnt_nxt = dec;
        if (dec == '0) begin
          run_nxt = 1'b0;
          if (step_r != '0) begin
            step_nxt = stp_inc;
            cnt_nxt  = fix_zero(rpt_dly);
            run_nxt  = 1'b1;
            evt.emit = 1'b1;
          end else if (pressed != lvl_r) begin
            lvl_nxt  = pressed;
            evt.emit = 1'b1;
            if (pressed) begin
              step_nxt = STEP_W'(1);
              cnt_nxt  = fix_zero(cfg.first);
              run_nxt  = 1'b1;
            end
          end
        end
      end
    end

    evt.pressed = lvl_nxt;
    evt.step    = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b1;
      lvl_r  <= 1'b0;
      run_r  <= 1'b0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      lvl_r  <= lvl_nxt;
      run_r  <= run_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ----- design/kda_merge.sv -----
// ----------------------------------------------------------------------------
// kda_merge: event merge and output stage
// Snapshots the lane events of a tick and drains them in key order.
// ----------------------------------------------------------------------------
module kda_merge import kda_pkg::*; #(
  parameter int KEYS = KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  kda_evt_t           evt [KEYS],
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic [KIDX_W-1:0]  out_key_index,
  output logic               out_is_pressed,
  output logic [STEP_W-1:0]  out_repeat_count,
  output logic               out_last_event,
  output kda_mrg_sts_t       sts
);

  localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;

  logic [KEYS-1:0]   pend_r, pend_nxt;
  logic              prs_r [KEYS];
  logic [STEP_W-1:0] stp_r [KEYS];

  logic              ov_r, ov_nxt;
  logic [KIDX_W-1:0] key_r;
  logic              opr_r;
  logic [STEP_W-1:0] ostp_r;
  logic              last_r;

  logic [KW-1:0]     sel;
  logic              take;

  always_comb begin
    sel = '0;
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        sel = KW'(k);
      end
    end
    sts.any  = |pend_r;
    sts.one  = sts.any && ((pend_r & (pend_r - KEYS'(1))) == '0);
    take     = !ov_r || !out_stall;
    sts.load = sts.any && take;
    in_stall = sts.any && !(sts.load && sts.one);

    pend_nxt = pend_r;
    if (sts.load) begin
      pend_nxt[sel] = 1'b0;
    end
    if (acc) begin
      for (int k = 0; k < KEYS; k++) begin
        pend_nxt[k] = evt[k].emit;
      end
    end
    ov_nxt = take ? sts.load : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < KEYS; k++) begin
        prs_r[k] <= evt[k].pressed;
        stp_r[k] <= evt[k].step;
      end
    end
    if (sts.load) begin
      key_r  <= KIDX_W'(sel);
      opr_r  <= prs_r[sel];
      ostp_r <= stp_r[sel];
      last_r <= sts.one;
    end
  end

  assign out_valid        = ov_r;
  assign out_key_index    = key_r;
  assign out_is_pressed   = opr_r;
  assign out_repeat_count = ostp_r;
  assign out_last_event   = last_r;

endmodule

// ----- design/key_debounce_autorepeat_unit.sv -----
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_unit: debounced keys with typematic repeat
// Path: the first event of a tick is registered in the merge snapshot, then in
//   the output register; further events follow one per cycle while out_stall is low.
// Throughput: a tick with no events every cycle; a tick with n events (up to
//   KEYS) holds the merge snapshot until its last event moves out.
// Reset (rst_n, synchronous): keys released, timers idle, steps zero,
//   registers at their defaults, no events pending.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_unit import kda_pkg::*; #(
  parameter int KEYS = KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // tick channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIN_W-1:0]  in_pin_levels,
  // event channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIDX_W-1:0] out_key_index,
  output logic              out_is_pressed,
  output logic [STEP_W-1:0] out_repeat_count,
  output logic              out_last_event,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Word index sits at paddr[4:2]; the write lands
  // on the access phase. Indexes past the map are dropped.
  // --------------------------------------------------------------------------
  kda_cfg_t cfg_r, cfg_nxt;
  kda_reg_t ridx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign ridx       = kda_reg_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_prdata = '0;
    case (ridx)
      REG_DEBOUNCE: begin
        cfg_prdata = APB_DW'(cfg_r.debounce);
        if (wr_en) cfg_nxt.debounce = cfg_pwdata[DBNC_W-1:0];
      end
      REG_FIRST: begin
        cfg_prdata = APB_DW'(cfg_r.first);
        if (wr_en) cfg_nxt.first = cfg_pwdata[CNT_W-1:0];
      end
      REG_MIDDLE: begin
        cfg_prdata = APB_DW'(cfg_r.middle);
        if (wr_en) cfg_nxt.middle = cfg_pwdata[CNT_W-1:0];
      end
      REG_FAST: begin
        cfg_prdata = APB_DW'(cfg_r.fast);
        if (wr_en) cfg_nxt.fast = cfg_pwdata[CNT_W-1:0];
      end
      REG_MID_LAST: begin
        cfg_prdata = APB_DW'(cfg_r.mid_last);
        if (wr_en) cfg_nxt.mid_last = cfg_pwdata[MLS_W-1:0];
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= DBNC_RST;
      cfg_r.first    <= FIRST_RST;
      cfg_r.middle   <= MID_RST;
      cfg_r.fast     <= FAST_RST;
      cfg_r.mid_last <= MLS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Key lanes. Every lane steps its own key on the accepted tick beat; keys
  // past the pin field see a released level and never fire.
  // --------------------------------------------------------------------------
  logic         tick;
  kda_evt_t     evt [KEYS];
  kda_mrg_sts_t msts;

  assign tick = in_valid && !in_stall;

  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    logic raw;
    if (k < PIN_W) begin : g_pin
      assign raw = in_pin_levels[k];
    end else begin : g_idle
      assign raw = 1'b1;
    end

    kda_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .tick  (tick),
      .raw   (raw),
      .cfg   (cfg_r),
      .evt   (evt[k])
    );
  end

  // --------------------------------------------------------------------------
  // Merge: hold the tick's events, drain lowest key first, flag the last one.
  // The next tick is taken in the cycle the last queued event moves out.
  // --------------------------------------------------------------------------
  kda_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (tick),
    .evt              (evt),
    .out_stall        (out_stall),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_key_index    (out_key_index),
    .out_is_pressed   (out_is_pressed),
    .out_repeat_count (out_repeat_count),
    .out_last_event   (out_last_event),
    .sts              (msts)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A tick is only taken once the snapshot is empty or its final event leaves.
  a_acc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!msts.any || (msts.one && msts.load)))
    else $error("tick accepted over queued events");

  // Moving the only queued event out marks it as the last of its tick.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (msts.load && msts.one) |=> (out_valid && out_last_event))
    else $error("last event of tick not flagged");

  // An event that is not the last must leave more of its tick queued.
  a_more_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_event) |-> msts.any)
    else $error("non-last event with nothing queued");

endmodule
